// ===== rtl/ufd_pkg.sv =====
// Shared types and constants for the UTF-8 validating decoder.
// No dependencies; imported by every module of the block.
package ufd_pkg;

	localparam int unsigned FifoDepth = 4;
	localparam int unsigned FifoAddrW = $clog2(FifoDepth);
	localparam int unsigned FifoCntW  = FifoAddrW + 1;

	localparam logic [20:0] MaxPoint   = 21'h10FFFF;
	localparam logic [20:0] SurrLow    = 21'h00D800;
	localparam logic [20:0] SurrHigh   = 21'h00DFFF;
	localparam logic [20:0] HiSurrBase = 21'h00D800;
	localparam logic [20:0] LoSurrBase = 21'h00DC00;
	localparam logic [20:0] PlaneOne   = 21'h010000;
	localparam logic [20:0] BmpMax     = 21'h00FFFF;
	localparam logic [20:0] Min2Byte   = 21'h000080;
	localparam logic [20:0] Min3Byte   = 21'h000800;

	typedef struct packed {
		logic [20:0] code_unit;
		logic        is_last;
		logic        bad_sequence;
	} result_t;

	// results produced for one byte: count is 0, 1 or 2
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

	function automatic push_t emit_point(logic [20:0] cp, logic eos, logic utf16);
		push_t       p;
		logic [20:0] v;
		v = cp - PlaneOne;
		if (utf16 && cp > BmpMax) begin
			p.count  = 2'd2;
			p.first  = '{code_unit: HiSurrBase + {11'd0, v[19:10]}, is_last: 1'b0,
				bad_sequence: 1'b0};
			p.second = '{code_unit: LoSurrBase + {11'd0, v[9:0]}, is_last: eos,
				bad_sequence: 1'b0};
		end else begin
			p.count  = 2'd1;
			p.first  = '{code_unit: cp, is_last: eos, bad_sequence: 1'b0};
			p.second = '0;
		end
		return p;
	endfunction

	function automatic push_t fail_result();
		push_t p;
		p.count  = 2'd1;
		p.first  = '{code_unit: 21'd0, is_last: 1'b1, bad_sequence: 1'b1};
		p.second = '0;
		return p;
	endfunction

endpackage

// ===== rtl/utf8_validating_decoder_core.sv =====
// UTF-8 validating decoder, top level: input register, config register,
// decode stage and result queue. Uses ufd_pkg, ufd_decode, ufd_out_fifo.
//
// Usage: bytes of a UTF-8 string enter on the s_axis stream, one per request,
// with s_axis_tlast on the final byte of each string. Decoded results leave on
// m_axis: code_unit in tdata, tlast marks the final result of a string (or an
// error), tuser flags an invalid string. On an error one result with code 0,
// tlast and tuser set is sent, and the rest of that string is dropped.
// cfg_data written on the cfg channel selects UTF-16 output (1, reset value)
// or whole code points (0); write it only while the block is idle.
// A byte is held in the input register and decoded there, and its results are
// written into the result queue, whose head is presented on m_axis.
// Throughput: one byte per cycle while the result queue has room; a surrogate
// pair gives two results; the single-result-per-cycle master port sets the rate.
// Reset clears the sequence state, the input register and the result queue.
// When the receiver stalls, the four-entry queue fills, the decode stage
// holds its byte, and s_axis_tready drops until room frees up.
module utf8_validating_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [20:0] code_unit, [23:21] zero
	output logic        m_axis_tlast,
	output logic        m_axis_tuser,  // [0] bad_sequence
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);
	import ufd_pkg::*;

	logic        utf16_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eos_s1;
	logic        room;
	logic        advance;
	push_t       push;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			utf16_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			utf16_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			eos_s1  <= s_axis_tlast;
		end
	end

	ufd_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.in_byte      (byte_s1),
		.end_of_string(eos_s1),
		.utf16_output (utf16_q),
		.push         (push)
	);

	ufd_out_fifo u_out_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room         (room),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

endmodule

// ===== rtl/ufd_decode.sv =====
// Sequence state and single-pass byte decode: lead/continuation checks,
// overlong, surrogate and range checks, UTF-16 split. Uses ufd_pkg.
module ufd_decode (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic [7:0]    in_byte,
	input  logic          end_of_string,
	input  logic          utf16_output,
	output ufd_pkg::push_t push
);
	import ufd_pkg::*;

	logic [20:0] partial_q;
	logic [1:0]  due_q;
	logic [1:0]  len_q;
	logic        discard_q;

	logic [20:0] partial_d;
	logic [1:0]  due_d;
	logic [1:0]  len_d;
	logic        discard_d;
	push_t       push_d;

	logic [20:0] cp;
	logic [20:0] minimum;
	logic [1:0]  due_dec;

	always_comb begin
		partial_d = partial_q;
		due_d     = due_q;
		len_d     = len_q;
		discard_d = discard_q;
		push_d    = '0;
		cp        = {partial_q[14:0], in_byte[5:0]};
		due_dec   = due_q - 2'd1;
		minimum   = (len_q == 2'd1) ? Min2Byte : (len_q == 2'd2) ? Min3Byte : PlaneOne;

		if (discard_q) begin
			// drop bytes through the end of the bad string
			if (end_of_string) discard_d = 1'b0;
		end else if (due_q == 2'd0) begin
			if (!in_byte[7]) begin
				push_d = emit_point({13'd0, in_byte}, end_of_string, utf16_output);
			end else if (in_byte[7:5] == 3'b110 || in_byte[7:4] == 4'b1110 ||
				in_byte[7:3] == 5'b11110) begin
				if (end_of_string) begin
					push_d = fail_result();
					partial_d = '0;
					due_d = '0;
					len_d = '0;
				end else if (in_byte[7:5] == 3'b110) begin
					partial_d = {16'd0, in_byte[4:0]};
					due_d = 2'd1;
					len_d = 2'd1;
				end else if (in_byte[7:4] == 4'b1110) begin
					partial_d = {17'd0, in_byte[3:0]};
					due_d = 2'd2;
					len_d = 2'd2;
				end else begin
					partial_d = {18'd0, in_byte[2:0]};
					due_d = 2'd3;
					len_d = 2'd3;
				end
			end else begin
				push_d = fail_result();
				partial_d = '0;
				due_d = '0;
				len_d = '0;
				discard_d = !end_of_string;
			end
		end else if (in_byte[7:6] != 2'b10) begin
			push_d = fail_result();
			partial_d = '0;
			due_d = '0;
			len_d = '0;
			discard_d = !end_of_string;
		end else if (due_dec != 2'd0) begin
			if (end_of_string) begin
				push_d = fail_result();
				partial_d = '0;
				due_d = '0;
				len_d = '0;
			end else begin
				partial_d = cp;
				due_d = due_dec;
			end
		end else begin
			partial_d = '0;
			due_d = '0;
			len_d = '0;
			if (cp < minimum || cp > MaxPoint || (cp >= SurrLow && cp <= SurrHigh)) begin
				push_d = fail_result();
				discard_d = !end_of_string;
			end else begin
				push_d = emit_point(cp, end_of_string, utf16_output);
			end
		end
	end

	always_comb begin
		push = push_d;
		if (!advance) push.count = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			due_q     <= '0;
			len_q     <= '0;
			discard_q <= 1'b0;
		end else if (advance) begin
			partial_q <= partial_d;
			due_q     <= due_d;
			len_q     <= len_d;
			discard_q <= discard_d;
		end
	end

endmodule

// ===== rtl/ufd_out_fifo.sv =====
// Small result queue taking up to two results a cycle and presenting one
// on the master stream. Uses ufd_pkg.
module ufd_out_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  ufd_pkg::push_t push,
	output logic           room,
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [23:0]    m_axis_tdata,  // [20:0] code_unit, [23:21] zero
	output logic           m_axis_tlast,
	output logic           m_axis_tuser   // [0] bad_sequence
);
	import ufd_pkg::*;

	result_t               mem [FifoDepth];
	logic [FifoAddrW-1:0]  head_q;
	logic [FifoAddrW-1:0]  tail_q;
	logic [FifoCntW-1:0]   count_q;
	logic [FifoCntW-1:0]   after_pop;
	logic                  pop;
	result_t               head_item;

	assign pop       = m_axis_tvalid && m_axis_tready;
	assign after_pop = count_q - {{(FifoCntW-1){1'b0}}, pop};
	assign room      = after_pop <= FifoCntW'(FifoDepth - 2);
	assign head_item = mem[head_q];

	assign m_axis_tvalid = count_q != '0;
	assign m_axis_tdata  = {3'd0, head_item.code_unit};
	assign m_axis_tlast  = head_item.is_last;
	assign m_axis_tuser  = head_item.bad_sequence;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) mem[tail_q] <= push.first;
		if (push.count == 2'd2) mem[tail_q + FifoAddrW'(1)] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) head_q <= head_q + FifoAddrW'(1);
			tail_q  <= tail_q + FifoAddrW'(push.count);
			count_q <= after_pop + FifoCntW'(push.count);
		end
	end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for utf8_validating_decoder_core: directed strings, then random
// strings in both output modes, checked against an in-bench decoder. Depends on ufd_pkg.
module testbench;
	import ufd_pkg::*;

	localparam int WatchLimit = 2000;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       typed;
		result_t    want;
	} stim_row_t;

	localparam result_t NoUnit    = '0;
	localparam result_t ErrorUnit = '{code_unit: 21'd0, is_last: 1'b1, bad_sequence: 1'b1};

	localparam stim_row_t DirectedRows[28] = '{
		'{8'h00, 1'b1, 1'b1, '{21'h00, 1'b1, 1'b0}},
		'{8'h7F, 1'b0, 1'b1, '{21'h7F, 1'b0, 1'b0}},
		'{8'hC2, 1'b0, 1'b0, NoUnit},     // lead only, nothing out yet
		'{8'h80, 1'b1, 1'b0, NoUnit},
		'{8'hE0, 1'b0, 1'b0, NoUnit},
		'{8'hA0, 1'b0, 1'b0, NoUnit},
		'{8'h80, 1'b0, 1'b0, NoUnit},
		'{8'hF0, 1'b0, 1'b0, NoUnit},     // lowest four-byte point, surrogate pair out
		'{8'h90, 1'b0, 1'b0, NoUnit},
		'{8'h80, 1'b0, 1'b0, NoUnit},
		'{8'h80, 1'b1, 1'b0, NoUnit},
		'{8'hFF, 1'b0, 1'b1, ErrorUnit},  // bad lead, rest of string dropped
		'{8'h41, 1'b0, 1'b0, NoUnit},
		'{8'h42, 1'b1, 1'b0, NoUnit},
		'{8'h80, 1'b1, 1'b1, ErrorUnit},  // stray continuation as lead
		'{8'hC0, 1'b0, 1'b0, NoUnit},     // overlong NUL
		'{8'h80, 1'b1, 1'b1, ErrorUnit},
		'{8'hED, 1'b0, 1'b0, NoUnit},     // encoded surrogate
		'{8'hA0, 1'b0, 1'b0, NoUnit},
		'{8'h80, 1'b1, 1'b1, ErrorUnit},
		'{8'hF4, 1'b0, 1'b0, NoUnit},     // just above the code space
		'{8'h90, 1'b0, 1'b0, NoUnit},
		'{8'h80, 1'b0, 1'b0, NoUnit},
		'{8'h80, 1'b1, 1'b1, ErrorUnit},
		'{8'hE2, 1'b0, 1'b0, NoUnit},     // cut off mid-sequence
		'{8'h82, 1'b1, 1'b1, ErrorUnit},
		'{8'hC3, 1'b0, 1'b0, NoUnit},     // non-continuation where one is due
		'{8'h41, 1'b1, 1'b1, ErrorUnit}
	};

	localparam logic [20:0] EdgePoints[11] = '{
		21'h0, 21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hD7FF,
		21'hE000, 21'hFFFF, 21'h10000, 21'h10FFFF, 21'hDC00
	};

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        m_axis_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;

	// decoder state mirrored by the bench
	logic [20:0] acc_point  = '0;
	logic [1:0]  due_count  = '0;
	logic [1:0]  seq_count  = '0;
	bit          dropping   = 1'b0;
	bit          utf16_mode = 1'b1;

	result_t     pending_units[$];
	logic [7:0]  string_bytes[$];
	int          fail_count   = 0;
	int          quiet_cycles = 0;
	bit          idling_on    = 1'b1;

	utf8_validating_decoder_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// append one expected result at the tail of the queue
	function automatic void queue_unit(result_t unit);
		pending_units = {pending_units, unit};
	endfunction

	function automatic void stash_byte(logic [7:0] b);
		string_bytes = {string_bytes, b};
	endfunction

	function automatic int queue_code_point(logic [20:0] cp, logic eos);
		logic [20:0] offset;
		if (utf16_mode && cp > BmpMax) begin
			offset = cp - PlaneOne;
			queue_unit('{code_unit: HiSurrBase + {11'd0, offset[19:10]},
				is_last: 1'b0, bad_sequence: 1'b0});
			queue_unit('{code_unit: LoSurrBase + {11'd0, offset[9:0]},
				is_last: eos, bad_sequence: 1'b0});
			return 2;
		end
		queue_unit('{code_unit: cp, is_last: eos, bad_sequence: 1'b0});
		return 1;
	endfunction

	function automatic int queue_error(logic eos);
		acc_point = '0;
		due_count = '0;
		seq_count = '0;
		dropping  = !eos;
		queue_unit(ErrorUnit);
		return 1;
	endfunction

	// returns the number of results the byte causes, or -1 if it is dropped
	function automatic int decode_byte(logic [7:0] b, logic eos);
		logic [1:0]  len;
		logic [20:0] floor_point;
		if (dropping) begin
			if (eos)
				dropping = 1'b0;
			return -1;
		end
		if (due_count == 2'd0) begin
			if (!b[7])
				return queue_code_point({13'd0, b}, eos);
			if (b[7:5] == 3'b110) begin
				len = 2'd1;
				acc_point = {16'd0, b[4:0]};
			end else if (b[7:4] == 4'b1110) begin
				len = 2'd2;
				acc_point = {17'd0, b[3:0]};
			end else if (b[7:3] == 5'b11110) begin
				len = 2'd3;
				acc_point = {18'd0, b[2:0]};
			end else begin
				return queue_error(eos);
			end
			if (eos)
				return queue_error(eos);
			due_count = len;
			seq_count = len;
			return 0;
		end
		if (b[7:6] != 2'b10)
			return queue_error(eos);
		acc_point = {acc_point[14:0], b[5:0]};
		due_count = due_count - 2'd1;
		if (due_count != 2'd0)
			return eos ? queue_error(eos) : 0;
		floor_point = (seq_count == 2'd1) ? Min2Byte : (seq_count == 2'd2) ? Min3Byte : PlaneOne;
		if (acc_point < floor_point || acc_point > MaxPoint ||
				(acc_point >= SurrLow && acc_point <= SurrHigh))
			return queue_error(eos);
		seq_count = '0;
		return queue_code_point(acc_point, eos);
	endfunction

	task automatic report_mismatch(string what, int unsigned got_val, int unsigned want_val);
		$display("%0t ns: %s mismatch: got 0x%0h, want 0x%0h", $time, what, got_val, want_val);
		fail_count++;
	endtask

	task automatic send_request(input logic [7:0] b, input logic eos, output int produced);
		if (idling_on && $urandom_range(0, 9) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= eos;
		do @(posedge clk); while (!s_axis_tready);
		produced = decode_byte(b, eos);
	endtask

	// drain the block, then switch the output mode
	task automatic set_output_mode(input bit mode);
		s_axis_tvalid <= 1'b0;
		while (pending_units.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		utf16_mode = mode;
	endtask

	task automatic pick_point(output logic [20:0] cp, output int len);
		case ($urandom_range(0, 9))
			0, 1, 2: cp = 21'($urandom_range(0, 'h7F));
			3:       cp = 21'($urandom_range('h80, 'h7FF));
			4, 5:    cp = 21'($urandom_range('h800, 'hFFFF));
			6, 7:    cp = 21'($urandom_range('h10000, 'h10FFFF));
			8:       cp = EdgePoints[$urandom_range(0, 10)];
			default: begin
				case ($urandom_range(0, 2))
					0: cp = 21'($urandom_range('hD800, 'hDFFF));
					1: cp = 21'($urandom_range('h110000, 'h1FFFFF));
					default: begin
						// overlong: one byte more than needed
						cp  = 21'($urandom_range(0, 'hFFFF));
						len = (cp < 'h80) ? 2 : (cp < 'h800) ? 3 : 4;
						return;
					end
				endcase
			end
		endcase
		len = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
	endtask

	task automatic append_encoded(input logic [20:0] cp, input int len);
		case (len)
			1: stash_byte({1'b0, cp[6:0]});
			2: begin
				stash_byte({3'b110, cp[10:6]});
				stash_byte({2'b10, cp[5:0]});
			end
			3: begin
				stash_byte({4'b1110, cp[15:12]});
				stash_byte({2'b10, cp[11:6]});
				stash_byte({2'b10, cp[5:0]});
			end
			default: begin
				stash_byte({5'b11110, cp[20:18]});
				stash_byte({2'b10, cp[17:12]});
				stash_byte({2'b10, cp[11:6]});
				stash_byte({2'b10, cp[5:0]});
			end
		endcase
	endtask

	// mostly well-formed strings, some broken ones, some raw noise
	task automatic run_random_strings(input int target);
		int taken;
		int kind;
		int produced;
		int len;
		logic [20:0] cp;
		taken = 0;
		while (taken < target) begin
			string_bytes.delete();
			kind = $urandom_range(0, 19);
			if (kind < 17) begin
				repeat ($urandom_range(1, 5)) begin
					pick_point(cp, len);
					append_encoded(cp, len);
				end
				if (kind >= 15) begin
					if ($urandom_range(0, 1) == 0)
						string_bytes[$urandom_range(0, string_bytes.size() - 1)] =
							8'($urandom_range(0, 255));
					else if (string_bytes.size() > 1)
						repeat ($urandom_range(1, string_bytes.size() - 1))
							void'(string_bytes.pop_back());
				end
			end else begin
				repeat ($urandom_range(1, 6))
					stash_byte(8'($urandom_range(0, 255)));
			end
			foreach (string_bytes[i]) begin
				send_request(string_bytes[i], i == string_bytes.size() - 1, produced);
				taken++;
			end
		end
	endtask

	// receiver with random stall bursts
	initial begin
		int stall_left;
		stall_left = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (idling_on && stall_left == 0 && $urandom_range(0, 9) == 0)
				stall_left = $urandom_range(1, 13);
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{code_unit: m_axis_tdata[20:0], is_last: m_axis_tlast,
				bad_sequence: m_axis_tuser};
			if (pending_units.size() == 0) begin
				report_mismatch("unexpected result, code_unit", got.code_unit, 0);
			end else begin
				want = pending_units.pop_front();
				if (got.code_unit != want.code_unit)
					report_mismatch("code_unit", got.code_unit, want.code_unit);
				if (got.is_last != want.is_last)
					report_mismatch("is_last", got.is_last, want.is_last);
				if (got.bad_sequence != want.bad_sequence)
					report_mismatch("bad_sequence", got.bad_sequence, want.bad_sequence);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= WatchLimit);
		$display("Verification failed");
		$finish;
	end

	initial begin
		int produced;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tlast  <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_data      <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed strings in the reset mode (UTF-16)
		foreach (DirectedRows[i]) begin
			send_request(DirectedRows[i].data, DirectedRows[i].last, produced);
			if (DirectedRows[i].typed) begin
				repeat (produced) void'(pending_units.pop_back());
				queue_unit(DirectedRows[i].want);
			end
		end

		set_output_mode(1'b0);
		run_random_strings(130);
		set_output_mode(1'b1);
		run_random_strings(130);
		set_output_mode(1'b0);
		run_random_strings(120);
		// last stretch at full rate on both sides
		idling_on = 1'b0;
		set_output_mode(1'b1);
		run_random_strings(120);

		s_axis_tvalid <= 1'b0;
		while (pending_units.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
